### src/polc_pkg.sv
// ----------------------------------------------------------------------------
// polc_pkg: shared types and constants for the positional ordered list
// Sizes, operation and status codes, and the control word that the
// sequencer broadcasts along the chain of storage cells.
// ----------------------------------------------------------------------------
package polc_pkg;

  localparam int CAPACITY   = 16;
  localparam int ITEM_BITS  = 32;

  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed transaction field widths
  localparam int ACT_W      = 3;
  localparam int POS_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int WHERE_W    = 6;
  localparam int ITEM_OUT_W = 32;
  localparam int LEN_W      = 5;

  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [WHERE_W-1:0] WHERE_FAIL = '1;  // -1

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT_AT     = 3'd0,
    ACT_INSERT_SORTED = 3'd1,
    ACT_ERASE_AT      = 3'd2,
    ACT_REMOVE_ALL    = 3'd3,
    ACT_GET           = 3'd4,
    ACT_SET           = 3'd5,
    ACT_FIND          = 3'd6
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  typedef enum logic [1:0] {
    CM_NONE,
    CM_INSERT,
    CM_ERASE,
    CM_WRITE
  } chain_mode_e;

  typedef struct packed {
    chain_mode_e            mode;
    logic [IDX_W-1:0]       at;
    logic [ITEM_BITS-1:0]   val;
  } chain_ctrl_t;

  typedef struct packed {
    status_e                status;
    logic [WHERE_W-1:0]     where;
    logic [ITEM_OUT_W-1:0]  item;
    logic [LEN_W-1:0]       removed;
    logic [LEN_W-1:0]       length;
    logic                   is_empty;
  } result_t;

endpackage

### src/polc_cell.sv
// ----------------------------------------------------------------------------
// polc_cell: one storage cell of the list chain
// Holds one item; takes its lower neighbor's item on insert, its upper
// neighbor's item on erase, or the broadcast value when addressed.
// ----------------------------------------------------------------------------
module polc_cell import polc_pkg::*; (
  input  logic                 clk_i,
  input  logic [IDX_W-1:0]     cell_idx_i,
  input  chain_ctrl_t          ctrl_i,
  input  logic [ITEM_BITS-1:0] lower_i,
  input  logic [ITEM_BITS-1:0] upper_i,
  output logic [ITEM_BITS-1:0] data_o
);

  logic [ITEM_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.mode)
      CM_NONE: ;
      CM_INSERT: begin
        if (cell_idx_i > ctrl_i.at) begin
          data_d = lower_i;
        end else if (cell_idx_i == ctrl_i.at) begin
          data_d = ctrl_i.val;
        end
      end
      CM_ERASE: begin
        if (cell_idx_i >= ctrl_i.at) begin
          data_d = upper_i;
        end
      end
      CM_WRITE: begin
        if (cell_idx_i == ctrl_i.at) begin
          data_d = ctrl_i.val;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### src/polc_ctrl.sv
// ----------------------------------------------------------------------------
// polc_ctrl: operation sequencer for the list chain
// Latches one operation, walks a scan index over the cells where a search
// is needed, drives the chain control word and holds the result register.
// ----------------------------------------------------------------------------
module polc_ctrl import polc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ACT_W-1:0]     in_action_i,
  input  logic [POS_W-1:0]     in_position_i,
  input  logic [VALUE_W-1:0]   in_value_i,
  input  logic [ITEM_BITS-1:0] cell_data_i [CAPACITY],
  output chain_ctrl_t          chain_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output result_t              result_o
);

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [ITEM_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     removed_q, removed_d;
  logic                 out_valid_q, out_valid_d;
  result_t              res_q, res_d;

  logic [IDX_W-1:0]     rd_idx;
  logic [ITEM_BITS-1:0] sel_data;
  logic                 lt_hit, eq_hit, scan_in, pos_gt_cnt, pos_ge_cnt, full;
  logic                 can_finish, done;
  chain_mode_e          nxt_mode;
  logic [IDX_W-1:0]     nxt_at;
  logic [CNT_W-1:0]     nxt_count, nxt_scan, nxt_removed;
  status_e              status;
  logic [WHERE_W-1:0]   where;
  logic [ITEM_OUT_W-1:0] item;

  // get reads at the given position, searches read at the scan index
  assign rd_idx     = (act_q == ACT_GET) ? IDX_W'(pos_q) : scan_q[IDX_W-1:0];
  assign sel_data   = cell_data_i[rd_idx];
  assign lt_hit     = sel_data < val_q;
  assign eq_hit     = sel_data == val_q;
  assign scan_in    = scan_q < count_q;
  assign pos_gt_cnt = CMP_W'(pos_q) > CMP_W'(count_q);
  assign pos_ge_cnt = CMP_W'(pos_q) >= CMP_W'(count_q);
  assign full       = count_q >= CNT_W'(CAPACITY);
  assign can_finish = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    pos_d       = pos_q;
    val_d       = val_q;
    scan_d      = scan_q;
    count_d     = count_q;
    removed_d   = removed_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = (state_q == S_IDLE);
    chain_o     = '{mode: CM_NONE, at: '0, val: val_q};

    done        = 1'b0;
    nxt_mode    = CM_NONE;
    nxt_at      = '0;
    nxt_count   = count_q;
    nxt_scan    = scan_q;
    nxt_removed = removed_q;
    status      = ST_OK;
    where       = '0;
    item        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_e'(in_action_i);
          pos_d     = in_position_i;
          val_d     = ITEM_BITS'(in_value_i);
          scan_d    = '0;
          removed_d = '0;
          state_d   = S_RUN;
        end
      end
      S_RUN: begin
        unique case (act_q)
          ACT_INSERT_AT: begin
            done = 1'b1;
            if (pos_gt_cnt) begin
              status = ST_MISS;
              where  = WHERE_FAIL;
            end else if (full) begin
              status = ST_FULL;
              where  = WHERE_FAIL;
            end else begin
              nxt_mode  = CM_INSERT;
              nxt_at    = IDX_W'(pos_q);
              nxt_count = count_q + CNT_W'(1);
              where     = WHERE_W'(pos_q);
            end
          end
          ACT_INSERT_SORTED: begin
            if (scan_in && lt_hit) begin
              nxt_scan = scan_q + CNT_W'(1);
            end else begin
              done = 1'b1;
              if (full) begin
                status = ST_FULL;
                where  = WHERE_FAIL;
              end else begin
                nxt_mode  = CM_INSERT;
                nxt_at    = scan_q[IDX_W-1:0];
                nxt_count = count_q + CNT_W'(1);
                where     = WHERE_W'(scan_q);
              end
            end
          end
          ACT_ERASE_AT, ACT_GET, ACT_SET: begin
            done = 1'b1;
            if (pos_ge_cnt) begin
              status = ST_MISS;
              where  = WHERE_FAIL;
            end else begin
              where  = WHERE_W'(pos_q);
              nxt_at = IDX_W'(pos_q);
              if (act_q == ACT_ERASE_AT) begin
                nxt_mode  = CM_ERASE;
                nxt_count = count_q - CNT_W'(1);
              end else if (act_q == ACT_GET) begin
                item = ITEM_OUT_W'(sel_data);
              end else begin
                nxt_mode = CM_WRITE;
              end
            end
          end
          ACT_REMOVE_ALL: begin
            // a match is erased in place; the scan index stays on the
            // survivor that slides down into it
            if (scan_in) begin
              if (eq_hit) begin
                nxt_mode    = CM_ERASE;
                nxt_at      = scan_q[IDX_W-1:0];
                nxt_count   = count_q - CNT_W'(1);
                nxt_removed = removed_q + CNT_W'(1);
              end else begin
                nxt_scan = scan_q + CNT_W'(1);
              end
            end else begin
              done = 1'b1;
            end
          end
          ACT_FIND: begin
            if (scan_in) begin
              if (eq_hit) begin
                done  = 1'b1;
                where = WHERE_W'(scan_q);
              end else begin
                nxt_scan = scan_q + CNT_W'(1);
              end
            end else begin
              done   = 1'b1;
              status = ST_MISS;
              where  = WHERE_FAIL;
            end
          end
          default: begin
            done   = 1'b1;
            status = ST_MISS;
            where  = WHERE_FAIL;
          end
        endcase

        // a finishing step waits, with nothing changed, for a free result slot
        if (!done || can_finish) begin
          chain_o.mode = nxt_mode;
          chain_o.at   = nxt_at;
          count_d      = nxt_count;
          scan_d       = nxt_scan;
          removed_d    = nxt_removed;
          if (done) begin
            res_d.status   = status;
            res_d.where    = where;
            res_d.item     = item;
            res_d.removed  = LEN_W'(nxt_removed);
            res_d.length   = LEN_W'(nxt_count);
            res_d.is_empty = (nxt_count == '0);
            out_valid_d    = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      count_q     <= count_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    pos_q <= pos_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

### src/positional_ordered_list_core.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_core: ordered list with positional and value ops
// A chain of item cells plus a sequencer; one result transaction per
// operation transaction.
// ----------------------------------------------------------------------------
// The block keeps a dense ordered list of up to CAPACITY items and runs one
// operation per input transaction: insert at a position, sorted insert,
// erase at a position, remove all matches, get, set and find. Each item
// lives in its own cell; inserts and erases move every cell above the
// position by one place in the same cycle, neighbor to neighbor. Insert_at,
// erase_at, get, set and unused codes need no scan; find and sorted insert
// walk the single scan index up to the first hit or the end of the list,
// and remove_all walks it over every entry, one examined or erased entry
// per cycle. A new operation is taken while the previous result still
// waits in the output register; a finished operation holds in place until
// that register frees. Every result carries the resulting length and an
// empty flag.
// ----------------------------------------------------------------------------
module positional_ordered_list_core import polc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation transaction
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // position[4:0], value[36:5], zero pad
  input  logic [2:0]  s_axis_tuser_i,   // action[2:0]
  // result transaction
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // status[1:0], where[7:2], item[39:8],
                                        // removed_count[44:40], length[49:45],
                                        // is_empty[50], zero pad
);

  localparam int OUT_USED_W = STATUS_W + WHERE_W + ITEM_OUT_W + LEN_W + LEN_W + 1;
  localparam int OUT_PAD_W  = 56 - OUT_USED_W;

  logic [ITEM_BITS-1:0] cell_data [CAPACITY];
  chain_ctrl_t          chain;
  result_t              result;

  polc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_action_i   (s_axis_tuser_i),
    .in_position_i (s_axis_tdata_i[POS_W-1:0]),
    .in_value_i    (s_axis_tdata_i[POS_W+VALUE_W-1:POS_W]),
    .cell_data_i   (cell_data),
    .chain_o       (chain),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .result_o      (result)
  );

  // cell chain: bottom cell has no lower neighbor, top cell re-takes itself
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ITEM_BITS-1:0] lower, upper;

    if (g == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign upper = cell_data[g];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end

    polc_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (chain),
      .lower_i    (lower),
      .upper_i    (upper),
      .data_o     (cell_data[g])
    );
  end

  // pack the result, first field in the low bits
  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}},
                           result.is_empty,
                           result.length,
                           result.removed,
                           result.item,
                           result.where,
                           result.status};

endmodule
